// ===== design/b2d_pkg.sv =====
// ----------------------------------------------------------------------------
// b2d_pkg: shared types and constants
// Widths, ASCII constants, controller states and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package b2d_pkg;

    localparam int VALUE_W = 31;
    localparam int CHAR_W = 6;
    localparam int DIGIT_W = 4;
    localparam int MAX_DIGITS_DEF = 10;
    localparam int BITCNT_W = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic bits_done;
        logic top_zero;
        logic overflow;
        logic last;
    } status_t;

endpackage

`default_nettype wire

// ===== design/b2d_in_if.sv =====
// ----------------------------------------------------------------------------
// b2d_in_if: input request channel
// Carries one binary value per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2d_in_if;
    logic                         valid;
    logic                         ready;
    logic [b2d_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== design/b2d_out_if.sv =====
// ----------------------------------------------------------------------------
// b2d_out_if: output request channel
// Carries one ASCII digit per request with a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2d_out_if;
    logic                        valid;
    logic                        ready;
    logic [b2d_pkg::CHAR_W-1:0]  digit_char;
    logic                        last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

// ===== design/b2d_datapath.sv =====
// ----------------------------------------------------------------------------
// b2d_datapath: shift-add-3 converter and digit shifter
// Holds the binary shift register, the bcd register, the bit counter and
// the remaining digit count.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_datapath #(
    parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire b2d_pkg::cmd_t                 cmd,
    input  wire logic [b2d_pkg::VALUE_W-1:0]   value,
    output b2d_pkg::status_t                   status,
    output logic [b2d_pkg::CHAR_W-1:0]         digit_char,
    output logic                               last_digit
);

    localparam int BCD_W = MAX_DIGITS * b2d_pkg::DIGIT_W;
    localparam int REM_W = $clog2(MAX_DIGITS + 1);
    localparam logic [b2d_pkg::BITCNT_W-1:0] LAST_BIT =
        b2d_pkg::BITCNT_W'(b2d_pkg::VALUE_W - 1);

    logic [b2d_pkg::VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]              bcd_reg, bcd_next;
    logic                          ovf_reg, ovf_next;
    logic [b2d_pkg::BITCNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [BCD_W-1:0]              bcd_adj;
    logic [b2d_pkg::DIGIT_W-1:0]   top_digit;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] >= 4'd5)
                bcd_adj[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] =
                    bcd_reg[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] + 4'd3;
            else
                bcd_adj[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] =
                    bcd_reg[i*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W];
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        ovf_next = ovf_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        if (cmd.load)
        begin
            bin_next = value;
            bcd_next = '0;
            ovf_next = 1'b0;
            cnt_next = '0;
            rem_next = REM_W'(MAX_DIGITS);
        end
        else if (cmd.step)
        begin
            bin_next = bin_reg << 1;
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[b2d_pkg::VALUE_W-1]};
            // a carry out of the top digit means more digits than slots
            ovf_next = ovf_reg | bcd_adj[BCD_W-1];
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.shift)
        begin
            bcd_next = bcd_reg << b2d_pkg::DIGIT_W;
            rem_next = rem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rem_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: b2d_pkg::DIGIT_W];

    assign status.bits_done = (cnt_reg == LAST_BIT);
    assign status.top_zero  = (top_digit == '0);
    assign status.overflow  = ovf_reg;
    assign status.last      = (rem_reg == REM_W'(1));

    assign digit_char = b2d_pkg::ASCII_ZERO + {2'b00, top_digit};
    assign last_digit = status.last;

endmodule

`default_nettype wire

// ===== design/b2d_controller.sv =====
// ----------------------------------------------------------------------------
// b2d_controller: sequencing state machine
// Runs load, conversion, leading zero skip and digit emission.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire b2d_pkg::status_t  status,
    output b2d_pkg::cmd_t          cmd
);

    b2d_pkg::state_t state_reg, state_next;
    logic skip;

    assign skip = !status.overflow && status.top_zero && !status.last;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            b2d_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = b2d_pkg::ST_CONVERT;
            end
            b2d_pkg::ST_CONVERT:
            begin
                if (status.bits_done)
                    state_next = b2d_pkg::ST_SCAN;
            end
            b2d_pkg::ST_SCAN:
            begin
                if (!skip)
                    state_next = b2d_pkg::ST_EMIT;
            end
            b2d_pkg::ST_EMIT:
            begin
                if (out_ready && status.last)
                    state_next = b2d_pkg::ST_IDLE;
            end
            default:
                state_next = b2d_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            b2d_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            b2d_pkg::ST_CONVERT:
                cmd.step = 1'b1;
            b2d_pkg::ST_SCAN:
                cmd.shift = skip;
            b2d_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.shift = out_ready && !status.last;
            end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= b2d_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== design/binary_to_decimal_ascii_unit.sv =====
// sequence: after a request the value is converted by shift-add-3 over all 31 bits, then
//   the scan state skips leading zeros one slot at a time, then the emit state shows digits
// a new request is taken only in idle, after the last digit is accepted; the
//   scan and emit states together always cover every digit slot once
// reset: rst_n asynchronous active low, returns the controller to idle
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit: binary to decimal ascii converter
// Converts a 31-bit value to ascii decimal digits, most significant first,
// without leading zeros, flagging the final digit.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_unit #(
    parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    b2d_in_if.sink         item,
    b2d_out_if.source      result
);

    // command and status between the sequencer and the datapath
    b2d_pkg::cmd_t    cmd;
    b2d_pkg::status_t status;

    // sequencer: idle, bit-serial conversion, leading zero skip, emission
    b2d_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: one bcd digit per slot, truncated to the low MAX_DIGITS digits;
    // a carry out of the top slot forces every slot to be emitted
    b2d_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (item.value),
        .status     (status),
        .digit_char (result.digit_char),
        .last_digit (result.last_digit)
    );

endmodule

`default_nettype wire

// ===== design/b2d_checker.sv =====
// ----------------------------------------------------------------------------
// b2d_checker: port level checks
// Watches the channels of the converter and is bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [b2d_pkg::CHAR_W-1:0]   digit_char,
    input wire logic                         last_digit
);

    // only one value in flight
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a digit is pending");

    // the conversion lies between a request and its first digit
    a_no_early_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("digit shown right after a request");

    // only decimal digit codes
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char >= b2d_pkg::ASCII_ZERO &&
                       digit_char <= b2d_pkg::ASCII_NINE))
        else $error("digit code out of range");

    // a stalled digit holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(digit_char) && $stable(last_digit)))
        else $error("stalled digit changed");

endmodule

bind binary_to_decimal_ascii_unit b2d_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .digit_char (result.digit_char),
    .last_digit (result.last_digit)
);

`default_nettype wire
